### rtl/cts_pkg.sv
// Shared types, constants and elaboration-time functions for the coordinate converter.
`default_nettype none
package cts_pkg;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned GUARD_BITS = 26;
   localparam int unsigned WORK_W = 62;
   localparam int unsigned ANG_W = 64;
   localparam int unsigned SQ_W = 64;
   localparam int unsigned SQ_STAGES = 32;

   localparam logic signed [ANG_W-1:0] PI_Q60 = 64'sh3243F6A8885A308D;
   localparam logic signed [ANG_W-1:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;
   localparam logic signed [31:0] PI_Q28 = 32'sd843314857;
   localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [ANG_W-1:0] ROUND_Q28 = 64'sh0000000080000000;

   typedef struct packed {
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic signed [31:0] point_weight;
      logic last_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] azimuth;
      logic [30:0] polar_angle;
      logic signed [31:0] weight_out;
      logic degenerate;
      logic last_out;
   } rsp_type;

   typedef enum logic [2:0] {
      PHI_ZERO,
      PHI_PI,
      PHI_POS_HALF,
      PHI_NEG_HALF,
      PHI_CORDIC
   } phi_sel_type;

   typedef enum logic [1:0] {
      TH_ZERO,
      TH_PI,
      TH_HALF,
      TH_CORDIC
   } theta_sel_type;

   typedef struct packed {
      logic signed [WORK_W-1:0] a;
      logic signed [WORK_W-1:0] b;
      logic signed [ANG_W-1:0] ang;
   } cordic_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] res;
   } sqrt_type;

   typedef struct packed {
      phi_sel_type phi_sel;
      theta_sel_type theta_sel;
      logic degenerate;
      logic last;
      logic signed [31:0] weight;
      logic signed [32:0] phi_a;
      logic signed [32:0] phi_b;
      logic x_neg;
      logic y_pos;
      logic signed [32:0] theta_a;
      logic z_neg;
   } meta_type;

   // Restoring division of constants; only ever evaluated at elaboration.
   function automatic logic [63:0] udiv_const(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) in Q3.60: pi/4 for i = 0, else from a truncated Taylor series.
   function automatic logic signed [63:0] atan_entry(input int unsigned i);
      logic signed [63:0] sum;
      logic [63:0] term;
      int unsigned p;
      sum = '0;
      if (i == 0) begin
         sum = QUARTER_PI_Q60;
      end else begin
         for (int unsigned k = 0; k < 64; k++) begin
            p = i * (2 * k + 1);
            if (p <= 60) begin
               term = udiv_const(64'd1 << (60 - p), 64'(2 * k + 1));
               if (k[0]) sum = sum - $signed(term);
               else sum = sum + $signed(term);
            end
         end
      end
      return sum;
   endfunction

endpackage
`default_nettype wire

### rtl/cts_isqrt_stage.sv
// One registered step of the digit-by-digit integer square root.
`default_nettype none
module cts_isqrt_stage #(
   parameter int unsigned BIT_POS = 62
) (
   input  wire logic                clock,
   input  wire cts_pkg::sqrt_type   stage_data,
   output      cts_pkg::sqrt_type   stage_out
);
   import cts_pkg::*;

   localparam logic [SQ_W:0] BIT_WIDE = (SQ_W+1)'(1) << BIT_POS;

   sqrt_type stage_ff, stage_in;
   logic [SQ_W:0] trial;

   always_comb begin
      trial = {1'b0, stage_data.res} + BIT_WIDE;
      if ({1'b0, stage_data.rem} >= trial) begin
         stage_in.rem = stage_data.rem - trial[SQ_W-1:0];
         stage_in.res = (stage_data.res >> 1) + BIT_WIDE[SQ_W-1:0];
      end else begin
         stage_in.rem = stage_data.rem;
         stage_in.res = stage_data.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

### rtl/cts_cordic_stage.sv
// One registered CORDIC vectoring iteration with a fixed shift and angle.
`default_nettype none
module cts_cordic_stage #(
   parameter int unsigned SHIFT = 0,
   parameter logic signed [63:0] ANGLE = 64'sd0
) (
   input  wire logic                clock,
   input  wire cts_pkg::cordic_type stage_data,
   output      cts_pkg::cordic_type stage_out
);
   import cts_pkg::*;

   cordic_type stage_ff, stage_in;
   logic signed [WORK_W-1:0] da, db;

   always_comb begin
      da = stage_data.b >>> SHIFT;
      db = stage_data.a >>> SHIFT;
      if (!stage_data.b[WORK_W-1]) begin
         stage_in.a = stage_data.a + da;
         stage_in.b = stage_data.b - db;
         stage_in.ang = stage_data.ang + ANGLE;
      end else begin
         stage_in.a = stage_data.a - da;
         stage_in.b = stage_data.b + db;
         stage_in.ang = stage_data.ang - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

### rtl/cartesian_to_spherical.sv
// Top level: pipelined Cartesian to spherical conversion of one point per clock.
// Stages in order: one capture stage, square, sum, 32 square root steps, the CORDIC
// stages and the output register.
// Throughput: one transaction per clock; busy is never raised.
// The receiver cannot stall, so every stage advances on every clock.
// Synchronous reset clears all valid bits; payload registers are not reset.
`default_nettype none
module cartesian_to_spherical #(
   parameter int unsigned CORDIC_STEPS = 30
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire cts_pkg::req_type req_data,
   output      logic             rsp_strobe,
   output      cts_pkg::rsp_type rsp_data
);
   import cts_pkg::*;

   // Index of the meta line after the square root is finished, and after the CORDIC.
   localparam int unsigned MID = 2 + SQ_STAGES;
   localparam int unsigned LAST = MID + CORDIC_STEPS;
   localparam int unsigned LATENCY = LAST + 2;

   // The pipeline never holds, so a new transaction is taken on every cycle.
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // Capture stage: classify the point and prepare magnitudes and CORDIC seeds.
   meta_type meta_in;
   logic [31:0] magx_in, magy_in;
   logic [31:0] magx_ff, magy_ff;
   logic signed [32:0] xs, ys, zs;
   logic x_zero, y_zero, z_zero;

   always_comb begin
      xs = {req_data.coord_x[31], req_data.coord_x};
      ys = {req_data.coord_y[31], req_data.coord_y};
      zs = {req_data.coord_z[31], req_data.coord_z};
      x_zero = (req_data.coord_x == '0);
      y_zero = (req_data.coord_y == '0);
      z_zero = (req_data.coord_z == '0);

      magx_in = req_data.coord_x[31] ? 32'(-xs) : 32'(xs);
      magy_in = req_data.coord_y[31] ? 32'(-ys) : 32'(ys);

      meta_in.degenerate = x_zero && y_zero && z_zero;
      meta_in.last = req_data.last_in;
      meta_in.weight = req_data.point_weight;
      meta_in.x_neg = req_data.coord_x[31];
      meta_in.y_pos = !req_data.coord_y[31] && !y_zero;
      meta_in.z_neg = req_data.coord_z[31];
      // The azimuth CORDIC always works in the right half plane.
      meta_in.phi_a = req_data.coord_x[31] ? -xs : xs;
      meta_in.phi_b = req_data.coord_x[31] ? -ys : ys;
      meta_in.theta_a = req_data.coord_z[31] ? -zs : zs;

      if (y_zero) begin
         meta_in.phi_sel = req_data.coord_x[31] ? PHI_PI : PHI_ZERO;
      end else if (x_zero) begin
         meta_in.phi_sel = req_data.coord_y[31] ? PHI_NEG_HALF : PHI_POS_HALF;
      end else begin
         meta_in.phi_sel = PHI_CORDIC;
      end

      if (x_zero && y_zero) begin
         // Covers the zero vector too: a zero z is not negative.
         meta_in.theta_sel = (z_zero || !req_data.coord_z[31]) ? TH_ZERO : TH_PI;
      end else if (z_zero) begin
         meta_in.theta_sel = TH_HALF;
      end else begin
         meta_in.theta_sel = TH_CORDIC;
      end
   end

   // Valid bits and sideband travel in lockstep with the datapath.
   logic     valid_ff [0:LAST];
   meta_type meta_ff  [0:LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= accept;
      end
      meta_ff[0] <= meta_in;
      magx_ff <= magx_in;
      magy_ff <= magy_in;
   end

   for (genvar k = 1; k <= LAST; k++) begin : g_line
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_ff[k-1];
         end
         meta_ff[k] <= meta_ff[k-1];
      end
   end

   // Squares of the magnitudes, then their sum.
   logic [SQ_W-1:0] sqx_ff, sqy_ff, sum_ff;

   always_ff @(posedge clock) begin
      sqx_ff <= magx_ff * magx_ff;
      sqy_ff <= magy_ff * magy_ff;
      sum_ff <= sqx_ff + sqy_ff;
   end

   // Floor square root, one result bit (two bits of the radicand) per stage.
   sqrt_type sq_stage [0:SQ_STAGES];

   assign sq_stage[0].rem = sum_ff;
   assign sq_stage[0].res = '0;

   for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
      cts_isqrt_stage #(
         .BIT_POS(62 - 2 * j)
      ) u_sqrt (
         .clock     (clock),
         .stage_data(sq_stage[j]),
         .stage_out (sq_stage[j+1])
      );
   end

   // Seed both CORDIC lanes once the in-plane radius is known.
   cordic_type phi_lane   [0:CORDIC_STEPS];
   cordic_type theta_lane [0:CORDIC_STEPS];
   logic signed [32:0] rxy;
   logic signed [32:0] theta_b;

   always_comb begin
      rxy = {1'b0, sq_stage[SQ_STAGES].res[31:0]};
      theta_b = meta_ff[MID].z_neg ? -rxy : rxy;

      phi_lane[0].a = {{3{meta_ff[MID].phi_a[32]}}, meta_ff[MID].phi_a, {GUARD_BITS{1'b0}}};
      phi_lane[0].b = {{3{meta_ff[MID].phi_b[32]}}, meta_ff[MID].phi_b, {GUARD_BITS{1'b0}}};
      if (!meta_ff[MID].x_neg) begin
         phi_lane[0].ang = '0;
      end else begin
         phi_lane[0].ang = meta_ff[MID].y_pos ? PI_Q60 : -PI_Q60;
      end

      theta_lane[0].a = {{3{meta_ff[MID].theta_a[32]}}, meta_ff[MID].theta_a,
                         {GUARD_BITS{1'b0}}};
      theta_lane[0].b = {{3{theta_b[32]}}, theta_b, {GUARD_BITS{1'b0}}};
      theta_lane[0].ang = meta_ff[MID].z_neg ? PI_Q60 : '0;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [ANG_W-1:0] STEP_ANGLE = atan_entry(i);

      cts_cordic_stage #(
         .SHIFT(i),
         .ANGLE(STEP_ANGLE)
      ) u_phi (
         .clock     (clock),
         .stage_data(phi_lane[i]),
         .stage_out (phi_lane[i+1])
      );

      cts_cordic_stage #(
         .SHIFT(i),
         .ANGLE(STEP_ANGLE)
      ) u_theta (
         .clock     (clock),
         .stage_data(theta_lane[i]),
         .stage_out (theta_lane[i+1])
      );
   end

   // Output stage: round to Q3.28, apply the special cases and clamp.
   logic signed [ANG_W-1:0] phi_round, theta_round;
   logic signed [31:0] phi_q, theta_q, phi_val, theta_val;
   rsp_type rsp_in, rsp_ff;
   logic    rsp_strobe_ff;

   always_comb begin
      phi_round = phi_lane[CORDIC_STEPS].ang + ROUND_Q28;
      theta_round = theta_lane[CORDIC_STEPS].ang + ROUND_Q28;
      phi_q = phi_round[ANG_W-1:32];
      theta_q = theta_round[ANG_W-1:32];

      case (meta_ff[LAST].phi_sel)
         PHI_PI:       phi_val = PI_Q28;
         PHI_POS_HALF: phi_val = HALF_PI_Q28;
         PHI_NEG_HALF: phi_val = -HALF_PI_Q28;
         PHI_CORDIC: begin
            if (phi_q > PI_Q28) phi_val = PI_Q28;
            else if (phi_q < -PI_Q28) phi_val = -PI_Q28;
            else phi_val = phi_q;
         end
         default:      phi_val = '0;
      endcase

      case (meta_ff[LAST].theta_sel)
         TH_PI:   theta_val = PI_Q28;
         TH_HALF: theta_val = HALF_PI_Q28;
         TH_CORDIC: begin
            if (theta_q < 0) theta_val = '0;
            else if (theta_q > PI_Q28) theta_val = PI_Q28;
            else theta_val = theta_q;
         end
         default: theta_val = '0;
      endcase

      rsp_in.azimuth = phi_val;
      rsp_in.polar_angle = theta_val[30:0];
      rsp_in.weight_out = meta_ff[LAST].weight;
      rsp_in.degenerate = meta_ff[LAST].degenerate;
      rsp_in.last_out = meta_ff[LAST].last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= valid_ff[LAST];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTH
   // Every result traces back to an accepted transaction.
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a matching accepted transaction");

   // A zero vector reports both angles as zero.
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.degenerate) |->
      (rsp_data.azimuth == '0 && rsp_data.polar_angle == '0))
      else $error("degenerate point with nonzero angle");

   // The polar angle never exceeds pi.
   a_theta_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($signed({1'b0, rsp_data.polar_angle}) <= PI_Q28))
      else $error("polar angle above pi");

   // The azimuth stays within minus pi and pi.
   a_phi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.azimuth <= PI_Q28 && rsp_data.azimuth >= -PI_Q28))
      else $error("azimuth out of range");
`endif

endmodule
`default_nettype wire
